// ----- hw/rtl/mlqs_pkg.sv -----
// Package for the multilevel queue scheduler: types, constants and a helper function.
`default_nettype none
package mlqs_pkg;
  localparam int unsigned SlotsDef = 16;
  localparam logic [15:0] AgingPeriodRst = 16'd1500;
  localparam logic [7:0]  AgingStepRst   = 8'd10;
  localparam logic [7:0]  MidFloorRst    = 8'd50;
  localparam logic [7:0]  TopFloorRst    = 8'd100;
  localparam logic [7:0]  PrioCap        = 8'd149;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_PICK   = 2'd1,
    CMD_AGE    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_STEP   = 2'd1,
    REG_MID    = 2'd2,
    REG_TOP    = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  function automatic logic [1:0] level_of(input logic [7:0] prio, input logic [7:0] top_f,
                                          input logic [7:0] mid_f);
    logic [1:0] lvl;
    if (prio >= top_f) lvl = 2'd1;
    else if (prio >= mid_f) lvl = 2'd2;
    else lvl = 2'd3;
    return lvl;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/multilevel_queue_scheduler_with_aging.sv -----
// Top level: multilevel ready-thread scheduler with aging over a slot table.
// Every command scans the whole slot table between the start edge and the done beat:
// one slot table entry per cycle is visited by a single shared compare/update unit.
// One command at a time; busy is high until the result beat is shown, so a new command is
// accepted only after the previous one has finished. Reset empties the table, clears the insert
// counter and preempt, loads register defaults. done_o lasts one cycle and cannot be stalled.
`default_nettype none
module multilevel_queue_scheduler_with_aging import mlqs_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         command_i,
  input  wire  [7:0]         thread_id_i,
  input  wire  [7:0]         priority_req_i,
  input  wire  signed [23:0] remaining_burst_i,
  input  wire  [31:0]        now_i,
  input  wire  [1:0]         running_level_i,
  input  wire  signed [23:0] running_remaining_i,
  input  wire                cfg_we_i,
  input  wire  [1:0]         cfg_idx_i,
  input  wire  [15:0]        cfg_data_i,
  output logic               done_o,
  output logic               picked_valid_o,
  output logic [7:0]         picked_id_o,
  output logic [1:0]         picked_level_o,
  output logic               preempt_o,
  output logic               table_full_o
);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [15:0] period_q;
  logic [7:0]  step_q, mid_q, top_q;

  logic [SLOTS-1:0] valid_q;
  logic [7:0]         thr_m  [SLOTS];
  logic [7:0]         pri_m  [SLOTS];
  logic [31:0]        wait_m [SLOTS];
  logic [31:0]        seen_m [SLOTS];
  logic signed [23:0] rem_m  [SLOTS];
  logic [15:0]        ord_m  [SLOTS];
  logic [15:0] ctr_q;
  logic        preempt_q;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] idx;
  logic [1:0] cmd_q, rlvl_q;
  logic [7:0] tid_q, preq_q;
  logic signed [23:0] burst_q, rrem_q;
  logic [31:0] now_q;

  logic          best_v_q;
  logic [IW-1:0] best_q;
  logic [1:0]    best_lvl_q;
  logic signed [23:0] best_rem_q;
  logic [7:0]    best_pri_q;
  logic [15:0]   best_age_q;
  logic          higher_q, have_top_q;
  logic signed [23:0] top_min_q;

  logic [7:0] cur_pri;
  logic [31:0] wsum, wnew;
  logic [8:0] psum;
  logic [7:0] pnew;
  logic [1:0] lvl, alvl;
  logic [15:0] age;
  logic better;
  logic accept;

  assign idx = cnt_q[IW-1:0];
  assign accept = start && !busy;
  assign busy = (state_q != ST_IDLE);

  always_comb begin
    cur_pri = pri_m[idx];
    lvl = level_of(cur_pri, top_q, mid_q);
    age = ctr_q - ord_m[idx];
    better = 1'b0;
    if (!best_v_q || lvl < best_lvl_q) better = 1'b1;
    else if (lvl == best_lvl_q) begin
      if (lvl == 2'd1 && rem_m[idx] != best_rem_q) better = rem_m[idx] < best_rem_q;
      else if (lvl == 2'd2 && cur_pri != best_pri_q) better = cur_pri > best_pri_q;
      else better = age > best_age_q;
    end
    wsum = wait_m[idx] + (now_q - seen_m[idx]);
    psum = {1'b0, cur_pri} + {1'b0, step_q};
    wnew = wsum;
    pnew = cur_pri;
    if (wsum > {16'd0, period_q}) begin
      wnew = wsum - {16'd0, period_q};
      pnew = (psum > {1'b0, PrioCap}) ? PrioCap : psum[7:0];
    end
    alvl = level_of(pnew, top_q, mid_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: if (cnt_q == CW'(SLOTS - 1)) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      period_q <= AgingPeriodRst;
      step_q <= AgingStepRst;
      mid_q <= MidFloorRst;
      top_q <= TopFloorRst;
      valid_q <= '0;
      ctr_q <= '0;
      preempt_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
      picked_valid_o <= 1'b0;
      picked_id_o <= '0;
      picked_level_o <= '0;
      table_full_o <= 1'b0;
      best_v_q <= 1'b0;
      best_q <= '0;
      higher_q <= 1'b0;
      have_top_q <= 1'b0;
      cmd_q <= CMD_NOP;
    end else begin
      state_q <= state_d;
      done_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_PERIOD: period_q <= cfg_data_i;
          REG_STEP:   step_q <= cfg_data_i[7:0];
          REG_MID:    mid_q <= cfg_data_i[7:0];
          REG_TOP:    top_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: if (accept) begin
          cmd_q <= command_i;
          cnt_q <= '0;
          best_v_q <= 1'b0;
          higher_q <= 1'b0;
          have_top_q <= 1'b0;
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + CW'(1);
          if (valid_q[idx]) begin
            if (cmd_q == CMD_PICK && better) begin
              best_v_q <= 1'b1;
              best_q <= idx;
            end
            if (cmd_q == CMD_AGE) begin
              if (alvl == 2'd1 && (!have_top_q || rem_m[idx] < top_min_q)) begin
                have_top_q <= 1'b1;
              end
              if (alvl < rlvl_q) higher_q <= 1'b1;
            end
          end else if (cmd_q == CMD_INSERT && !best_v_q) begin
            best_v_q <= 1'b1;
            best_q <= idx;
          end
        end
        ST_DONE: begin
          done_o <= 1'b1;
          picked_valid_o <= 1'b0;
          picked_id_o <= '0;
          picked_level_o <= '0;
          table_full_o <= 1'b0;
          unique case (cmd_e'(cmd_q))
            CMD_INSERT: begin
              if (best_v_q) begin
                valid_q[best_q] <= 1'b1;
                ctr_q <= ctr_q + 16'd1;
              end else table_full_o <= 1'b1;
            end
            CMD_PICK: if (best_v_q) begin
              picked_valid_o <= 1'b1;
              picked_id_o <= thr_m[best_q];
              picked_level_o <= best_lvl_q;
              valid_q[best_q] <= 1'b0;
            end
            CMD_AGE: preempt_q <= higher_q || (have_top_q && top_min_q < rrem_q);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rlvl_q <= running_level_i;
      tid_q <= thread_id_i;
      preq_q <= (priority_req_i > PrioCap) ? PrioCap : priority_req_i;
      burst_q <= remaining_burst_i;
      rrem_q <= running_remaining_i;
      now_q <= now_i;
    end
    if (state_q == ST_SCAN && valid_q[idx]) begin
      if (cmd_q == CMD_PICK && better) begin
        best_lvl_q <= lvl;
        best_rem_q <= rem_m[idx];
        best_pri_q <= cur_pri;
        best_age_q <= age;
      end
      if (cmd_q == CMD_AGE) begin
        wait_m[idx] <= wnew;
        seen_m[idx] <= now_q;
        pri_m[idx] <= pnew;
        if (alvl == 2'd1 && (!have_top_q || rem_m[idx] < top_min_q)) top_min_q <= rem_m[idx];
      end
    end
    if (state_q == ST_DONE && cmd_q == CMD_INSERT && best_v_q) begin
      thr_m[best_q] <= tid_q;
      pri_m[best_q] <= preq_q;
      rem_m[best_q] <= burst_q;
      wait_m[best_q] <= '0;
      seen_m[best_q] <= now_q;
      ord_m[best_q] <= ctr_q;
    end
  end

  assign preempt_o = preempt_q;

`ifndef NO_ASSERTIONS
  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_DONE)) else $error("done without finish");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> busy) else $error("scan while not busy");
  a_pick_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !picked_valid_o |-> (picked_level_o == 2'd0 && picked_id_o == 8'd0))
    else $error("stale pick fields");
  a_full_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> (cmd_q == CMD_INSERT && valid_q == {SLOTS{1'b1}}))
    else $error("full flag wrong");
`endif
endmodule
`default_nettype wire
